[rtl/plane_primitive_collision_test_unit_macros.svh]
// Assertion helpers for the plane collision test unit.
// Each expects clk and rst_n in scope.
`ifndef PLANE_PRIMITIVE_COLLISION_TEST_UNIT_MACROS_SVH
`define PLANE_PRIMITIVE_COLLISION_TEST_UNIT_MACROS_SVH

// Condition must never hold.
`define PPCT_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ppct: forbidden condition seen");

// Consequent holds in the same cycle.
`define PPCT_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppct: implication failed");

// Consequent holds in the following cycle.
`define PPCT_ASSERT_IMPLY_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppct: next-cycle implication failed");

`endif

[rtl/ppct_pkg.sv]
package ppct_pkg;

    typedef logic signed [31:0] fx_t;
    typedef fx_t [2:0]          vec_t;
    typedef logic signed [65:0] wide_t;
    typedef logic signed [63:0] prod_t;

    typedef enum logic [2:0] {
        CMD_SPHERE  = 3'd0,
        CMD_LINE    = 3'd1,
        CMD_RAY     = 3'd2,
        CMD_SEGMENT = 3'd3,
        CMD_CAPSULE = 3'd4,
        CMD_BOX     = 3'd5
    } cmd_t;

    localparam logic [2:0] REG_NORMAL_X      = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y      = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z      = 3'd2;
    localparam logic [2:0] REG_OFFSET        = 3'd3;
    localparam logic [2:0] REG_HAS_EFFECTIVE = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam wide_t FX_MAX = 66'sd2147483647;
    localparam wide_t FX_MIN = -66'sd2147483648;

    typedef struct packed {
        vec_t n;
        fx_t  d;
    } plane_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        respect;
        vec_t        a;
        vec_t        b;
        vec_t        dir;
        vec_t        m;
        vec_t        qbox;
        fx_t         da;
        fx_t         db;
        fx_t         den;
        fx_t         depth;
        logic [30:0] r;
    } item_t;

    function automatic wide_t wext(input fx_t x);
        wide_t w;
        w = wide_t'(x);
        return w;
    endfunction

    function automatic fx_t sat32(input wide_t v);
        fx_t res;
        if (v > FX_MAX)
        begin
            res = 32'sh7fffffff;
        end
        else if (v < FX_MIN)
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[rtl/plane_primitive_collision_test_unit.sv]
// Plane versus primitive collision test. Each request carries one sphere, line, ray,
// segment, capsule or axis-aligned box in the plane's frame and yields exactly one
// result: hit, surface point, deepest interior point and whether the effective normal
// applies. All values are signed fixed point with FRAC_BITS fraction bits; products,
// sums and the crossing parameter saturate to 32 bits. Throughput is one request per
// clock when out_ready stays high. An accepted request passes the front end, the queue,
// the crossing-parameter divider, which retires one quotient bit per stage
// (32 + FRAC_BITS stages), the operand stage and the result register that raises
// out_valid. A three-stage front end computes plane distances and feeds a four-entry
// queue; a stalled output holds the back end while the front keeps accepting until the
// queue fills. Plane registers may only be written while no request is in flight. The
// effective normal vector registers are accepted but not stored, since only its enable
// reaches the result.
module plane_primitive_collision_test_unit #(
    parameter int FRAC_BITS     = 16,
    parameter int TIE_TOLERANCE = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic signed [31:0] point_a_x,
    input  logic signed [31:0] point_a_y,
    input  logic signed [31:0] point_a_z,
    input  logic signed [31:0] point_b_x,
    input  logic signed [31:0] point_b_y,
    input  logic signed [31:0] point_b_z,
    input  logic [30:0]        radius,
    input  logic               respect_effective,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic               surface_valid,
    output logic signed [31:0] surface_x,
    output logic signed [31:0] surface_y,
    output logic signed [31:0] surface_z,
    output logic               interior_valid,
    output logic signed [31:0] interior_x,
    output logic signed [31:0] interior_y,
    output logic signed [31:0] interior_z,
    output logic               uses_effective_normal
);
    import ppct_pkg::*;

    localparam fx_t ONE_FX = fx_t'(1) <<< FRAC_BITS;

    plane_t plane_reg;
    logic   eff_on_reg;

    logic   q_push, q_full, q_pop, q_empty;
    item_t  q_push_item, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.n[0] <= '0;
            plane_reg.n[1] <= '0;
            plane_reg.n[2] <= ONE_FX;
            plane_reg.d    <= '0;
            eff_on_reg     <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_NORMAL_X:      plane_reg.n[0] <= cfg_data;
                REG_NORMAL_Y:      plane_reg.n[1] <= cfg_data;
                REG_NORMAL_Z:      plane_reg.n[2] <= cfg_data;
                REG_OFFSET:        plane_reg.d    <= cfg_data;
                REG_HAS_EFFECTIVE: eff_on_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ppct_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .point_a_x        (point_a_x),
        .point_a_y        (point_a_y),
        .point_a_z        (point_a_z),
        .point_b_x        (point_b_x),
        .point_b_y        (point_b_y),
        .point_b_z        (point_b_z),
        .radius           (radius),
        .respect_effective(respect_effective),
        .plane            (plane_reg),
        .full             (q_full),
        .push             (q_push),
        .push_item        (q_push_item)
    );

    ppct_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_item(q_push_item),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    ppct_back #(
        .FRAC_BITS    (FRAC_BITS),
        .TIE_TOLERANCE(TIE_TOLERANCE)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .empty                (q_empty),
        .head                 (q_head),
        .pop                  (q_pop),
        .plane                (plane_reg),
        .eff_on               (eff_on_reg),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .hit                  (hit),
        .surface_valid        (surface_valid),
        .surface_x            (surface_x),
        .surface_y            (surface_y),
        .surface_z            (surface_z),
        .interior_valid       (interior_valid),
        .interior_x           (interior_x),
        .interior_y           (interior_y),
        .interior_z           (interior_z),
        .uses_effective_normal(uses_effective_normal)
    );

`include "plane_primitive_collision_test_unit_macros.svh"

    `PPCT_ASSERT_NEVER(a_push_when_full, q_push && q_full)
    `PPCT_ASSERT_IMPLY(a_pop_needs_entry, q_pop, !q_empty)
    `PPCT_ASSERT_IMPLY_NEXT(a_push_fills_queue, q_push && !q_pop, !q_empty)
    `PPCT_ASSERT_IMPLY(a_flags_need_hit,
        out_valid && (surface_valid || interior_valid || uses_effective_normal), hit)

endmodule

[rtl/ppct_queue.sv]
module ppct_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ppct_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ppct_pkg::item_t head
);
    import ppct_pkg::*;

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_reg, wr_next;
    logic [QUEUE_AW-1:0]   rd_reg, rd_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

[rtl/ppct_front.sv]
module ppct_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          command,
    input  logic signed [31:0]  point_a_x,
    input  logic signed [31:0]  point_a_y,
    input  logic signed [31:0]  point_a_z,
    input  logic signed [31:0]  point_b_x,
    input  logic signed [31:0]  point_b_y,
    input  logic signed [31:0]  point_b_z,
    input  logic [30:0]         radius,
    input  logic                respect_effective,
    input  ppct_pkg::plane_t    plane,
    input  logic                full,
    output logic                push,
    output ppct_pkg::item_t     push_item
);
    import ppct_pkg::*;

    logic        en;
    logic        v1_reg, v2_reg, v3_reg;

    cmd_t        cmd1_reg, cmd2_reg, cmd3_reg;
    logic        resp1_reg, resp2_reg, resp3_reg;
    logic [30:0] r1_reg, r2_reg, r3_reg;
    vec_t        a1_reg, b1_reg;
    vec_t        a2_reg, b2_reg, dir2_reg, m2_reg;
    vec_t        a3_reg, b3_reg, dir3_reg, m3_reg, qbox3_reg;
    prod_t       pa2_reg [3];
    prod_t       pb2_reg [3];
    prod_t       pv3_reg [3];
    fx_t         da3_reg, db3_reg;
    wide_t       absdx3_reg;

    vec_t        dir2_next, m2_next, qbox3_next;
    prod_t       pa2_next [3];
    prod_t       pb2_next [3];
    prod_t       pv3_next [3];
    fx_t         da3_next, db3_next;
    wide_t       absdx3_next;
    fx_t         den_next, depth_next;

    // whole front stalls together while the queue is full
    assign en       = !full;
    assign in_ready = en;
    assign push     = v3_reg && en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir2_next[i] = sat32(wext(b1_reg[i]) - wext(a1_reg[i]));
            m2_next[i]   = sat32(wext(a1_reg[i]) + (wext(dir2_next[i]) >>> 1));
            pa2_next[i]  = 64'(a1_reg[i]) * 64'(plane.n[i]);
            pb2_next[i]  = 64'(b1_reg[i]) * 64'(plane.n[i]);
        end
    end

    always_comb
    begin
        prod_t dx;
        fx_t   vsel;
        wide_t sa, sb;
        sa          = wext(plane.d);
        sb          = wext(plane.d);
        absdx3_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            sa = sa + wide_t'(pa2_reg[i] >>> FRAC_BITS);
            dx = pb2_reg[i] >>> FRAC_BITS;
            sb = sb + wide_t'(dx);
            if (dx < 0)
            begin
                qbox3_next[i] = sat32(wext(a2_reg[i]) + wext(b2_reg[i]));
                absdx3_next   = absdx3_next - wide_t'(dx);
            end
            else if (dx > 0)
            begin
                qbox3_next[i] = sat32(wext(a2_reg[i]) - wext(b2_reg[i]));
                absdx3_next   = absdx3_next + wide_t'(dx);
            end
            else
            begin
                qbox3_next[i] = a2_reg[i];
            end
            vsel = (cmd2_reg == CMD_LINE || cmd2_reg == CMD_RAY) ? b2_reg[i] : dir2_reg[i];
            pv3_next[i] = 64'(vsel) * 64'(plane.n[i]);
        end
        da3_next = sat32(sa);
        db3_next = sat32(sb);
    end

    always_comb
    begin
        wide_t sv;
        sv = '0;
        for (int i = 0; i < 3; i++)
        begin
            sv = sv + wide_t'(pv3_reg[i] >>> FRAC_BITS);
        end
        den_next   = sat32(sv);
        depth_next = sat32(wext(da3_reg) - absdx3_reg);
    end

    always_comb
    begin
        push_item.cmd     = cmd3_reg;
        push_item.respect = resp3_reg;
        push_item.a       = a3_reg;
        push_item.b       = b3_reg;
        push_item.dir     = dir3_reg;
        push_item.m       = m3_reg;
        push_item.qbox    = qbox3_reg;
        push_item.da      = da3_reg;
        push_item.db      = db3_reg;
        push_item.den     = den_next;
        push_item.depth   = depth_next;
        push_item.r       = r3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg   <= cmd_t'(command);
            resp1_reg  <= respect_effective;
            r1_reg     <= radius;
            a1_reg     <= {point_a_z, point_a_y, point_a_x};
            b1_reg     <= {point_b_z, point_b_y, point_b_x};

            cmd2_reg   <= cmd1_reg;
            resp2_reg  <= resp1_reg;
            r2_reg     <= r1_reg;
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            dir2_reg   <= dir2_next;
            m2_reg     <= m2_next;
            pa2_reg    <= pa2_next;
            pb2_reg    <= pb2_next;

            cmd3_reg   <= cmd2_reg;
            resp3_reg  <= resp2_reg;
            r3_reg     <= r2_reg;
            a3_reg     <= a2_reg;
            b3_reg     <= b2_reg;
            dir3_reg   <= dir2_reg;
            m3_reg     <= m2_reg;
            qbox3_reg  <= qbox3_next;
            da3_reg    <= da3_next;
            db3_reg    <= db3_next;
            absdx3_reg <= absdx3_next;
            pv3_reg    <= pv3_next;
        end
    end

endmodule

[rtl/ppct_back.sv]
module ppct_back #(
    parameter int FRAC_BITS     = 16,
    parameter int TIE_TOLERANCE = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  ppct_pkg::item_t    head,
    output logic               pop,
    input  ppct_pkg::plane_t   plane,
    input  logic               eff_on,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic               surface_valid,
    output logic signed [31:0] surface_x,
    output logic signed [31:0] surface_y,
    output logic signed [31:0] surface_z,
    output logic               interior_valid,
    output logic signed [31:0] interior_x,
    output logic signed [31:0] interior_y,
    output logic signed [31:0] interior_z,
    output logic               uses_effective_normal
);
    import ppct_pkg::*;

    localparam int  NW     = 32 + FRAC_BITS;
    localparam fx_t ONE_FX = fx_t'(1) <<< FRAC_BITS;

    logic           adv;

    // quotient pipeline, one bit per stage
    logic [NW:0]    dv_reg;
    item_t          dp_reg   [NW+1];
    logic [31:0]    rem_reg  [NW+1];
    logic [NW-1:0]  num_reg  [NW+1];
    logic [NW-1:0]  quo_reg  [NW+1];
    logic [31:0]    dmag_reg [NW+1];
    logic           neg_reg  [NW+1];

    logic [31:0]    rem_next [NW];
    logic [NW-1:0]  num_next [NW];
    logic [NW-1:0]  quo_next [NW];
    logic [32:0]    da_mag_next, den_mag_next;

    // operand stage
    logic           mv_reg, m_hit_reg, m_sv_reg, m_iv_reg, m_sub_reg, m_uses_reg;
    vec_t           m_sbase_reg, m_qbase_reg;
    prod_t          m_sprod_reg [3];
    prod_t          m_qprod_reg [3];

    logic           m_hit_next, m_sv_next, m_iv_next, m_sub_next, m_uses_next;
    vec_t           m_sbase_next, m_qbase_next;
    prod_t          m_sprod_next [3];
    prod_t          m_qprod_next [3];

    // result register
    logic           out_valid_reg, hit_reg, sv_reg, iv_reg, uses_reg;
    vec_t           s_reg, q_reg, s_next, q_next;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !empty;

    assign da_mag_next  = head.da[31] ? 33'd0 - {head.da[31], head.da}
                                      : {1'b0, head.da};
    assign den_mag_next = head.den[31] ? 33'd0 - {head.den[31], head.den}
                                       : {1'b0, head.den};

    always_comb
    begin
        logic [32:0] trial;
        logic        ge;
        for (int k = 0; k < NW; k++)
        begin
            trial       = {rem_reg[k], num_reg[k][NW-1]};
            ge          = trial >= {1'b0, dmag_reg[k]};
            rem_next[k] = ge ? 32'(trial - {1'b0, dmag_reg[k]}) : trial[31:0];
            num_next[k] = num_reg[k] << 1;
            quo_next[k] = {quo_reg[k][NW-2:0], ge};
        end
    end

    // t, classification and multiplier operands
    always_comb
    begin
        item_t        p;
        wide_t        qw, qadj;
        fx_t          t_val, t_sel, r_ext, s_k, q_k, sx, sy, qx;
        logic         par, s_use_t, q_use_n;
        vec_t         s_vec;
        logic signed [32:0] dd, sum33;
        logic [32:0]  dabs;
        vec_t         mid;

        p     = dp_reg[NW];
        qw    = {{(66-NW){1'b0}}, quo_reg[NW]};
        qadj  = (neg_reg[NW] && rem_reg[NW] != '0) ? qw + 66'sd1 : qw;
        t_val = sat32(neg_reg[NW] ? -qadj : qadj);
        par   = (p.den == '0);
        r_ext = fx_t'({1'b0, p.r});

        dd   = {p.da[31], p.da} - {p.db[31], p.db};
        dabs = dd[32] ? 33'd0 - dd : dd;
        for (int i = 0; i < 3; i++)
        begin
            sum33  = {p.a[i][31], p.a[i]} + {p.b[i][31], p.b[i]};
            mid[i] = sum33[32:1];
        end

        m_hit_next   = 1'b0;
        m_sv_next    = 1'b0;
        m_iv_next    = 1'b0;
        m_sub_next   = 1'b1;
        s_use_t      = 1'b0;
        t_sel        = t_val;
        s_vec        = p.b;
        s_k          = p.da;
        m_sbase_next = p.a;
        m_qbase_next = p.a;
        q_use_n      = 1'b0;
        q_k          = r_ext;

        case (p.cmd)
            CMD_SPHERE:
            begin
                if (p.da <= r_ext)
                begin
                    m_hit_next = 1'b1;
                    m_sv_next  = 1'b1;
                    m_iv_next  = 1'b1;
                    q_use_n    = 1'b1;
                end
            end
            CMD_LINE:
            begin
                if (!(par && p.da > 0))
                begin
                    m_hit_next = 1'b1;
                    m_sv_next  = 1'b1;
                    s_use_t    = 1'b1;
                    m_sub_next = 1'b0;
                    t_sel      = par ? '0 : t_val;
                end
            end
            CMD_RAY:
            begin
                // origin behind the plane reports the origin itself
                if (p.da < 0 || (!par && t_val >= 0))
                begin
                    m_hit_next = 1'b1;
                    m_sv_next  = 1'b1;
                    s_use_t    = 1'b1;
                    m_sub_next = 1'b0;
                    t_sel      = (p.da < 0) ? '0 : t_val;
                end
            end
            CMD_SEGMENT:
            begin
                if (!(p.da >= 0 && p.db >= 0))
                begin
                    m_hit_next = 1'b1;
                    m_iv_next  = 1'b1;
                    if (p.da < p.db)
                    begin
                        m_qbase_next = p.a;
                    end
                    else if (p.db < p.da)
                    begin
                        m_qbase_next = p.b;
                    end
                    else
                    begin
                        m_qbase_next = mid;
                    end
                    if (!par && t_val >= 0 && t_val <= ONE_FX)
                    begin
                        m_sv_next  = 1'b1;
                        s_use_t    = 1'b1;
                        m_sub_next = 1'b0;
                        s_vec      = p.dir;
                    end
                end
            end
            CMD_CAPSULE:
            begin
                if (!(p.da >= r_ext && p.db >= r_ext))
                begin
                    m_hit_next = 1'b1;
                    m_sv_next  = 1'b1;
                    m_iv_next  = 1'b1;
                    q_use_n    = 1'b1;
                    if (par)
                    begin
                        m_sbase_next = p.m;
                    end
                    else if (t_val >= ONE_FX)
                    begin
                        m_sbase_next = p.b;
                        s_k          = p.db;
                    end
                    else if (t_val > 0)
                    begin
                        s_use_t    = 1'b1;
                        m_sub_next = 1'b0;
                        s_vec      = p.dir;
                    end
                    if (dabs <= 33'(TIE_TOLERANCE))
                    begin
                        m_qbase_next = p.m;
                    end
                    else if (p.da < p.db)
                    begin
                        m_qbase_next = p.a;
                    end
                    else
                    begin
                        m_qbase_next = p.b;
                    end
                end
            end
            CMD_BOX:
            begin
                if (p.depth <= 0)
                begin
                    m_hit_next   = 1'b1;
                    m_sv_next    = 1'b1;
                    m_iv_next    = 1'b1;
                    m_sbase_next = p.qbox;
                    m_qbase_next = p.qbox;
                    s_k          = p.depth;
                end
            end
            default:
            begin
            end
        endcase

        m_uses_next = m_hit_next && eff_on && p.respect;

        for (int i = 0; i < 3; i++)
        begin
            sx = s_use_t ? t_sel : plane.n[i];
            sy = s_use_t ? s_vec[i] : s_k;
            qx = q_use_n ? plane.n[i] : '0;
            m_sprod_next[i] = 64'(sx) * 64'(sy);
            m_qprod_next[i] = 64'(qx) * 64'(q_k);
        end
    end

    always_comb
    begin
        wide_t sh, qh;
        for (int i = 0; i < 3; i++)
        begin
            sh = wide_t'(m_sprod_reg[i] >>> FRAC_BITS);
            qh = wide_t'(m_qprod_reg[i] >>> FRAC_BITS);
            s_next[i] = m_sv_reg
                ? sat32(wext(m_sbase_reg[i]) + (m_sub_reg ? -sh : sh)) : '0;
            q_next[i] = m_iv_reg ? sat32(wext(m_qbase_reg[i]) - qh) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg        <= '0;
            mv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg        <= {dv_reg[NW-1:0], pop};
            mv_reg        <= dv_reg[NW];
            out_valid_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp_reg[0]   <= head;
            rem_reg[0]  <= '0;
            num_reg[0]  <= {da_mag_next[31:0], {FRAC_BITS{1'b0}}};
            quo_reg[0]  <= '0;
            dmag_reg[0] <= den_mag_next[31:0];
            neg_reg[0]  <= (head.da > 0) ^ head.den[31];
            for (int k = 0; k < NW; k++)
            begin
                dp_reg[k+1]   <= dp_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                num_reg[k+1]  <= num_next[k];
                quo_reg[k+1]  <= quo_next[k];
                dmag_reg[k+1] <= dmag_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
            end

            m_hit_reg   <= m_hit_next;
            m_sv_reg    <= m_sv_next;
            m_iv_reg    <= m_iv_next;
            m_sub_reg   <= m_sub_next;
            m_uses_reg  <= m_uses_next;
            m_sbase_reg <= m_sbase_next;
            m_qbase_reg <= m_qbase_next;
            m_sprod_reg <= m_sprod_next;
            m_qprod_reg <= m_qprod_next;

            hit_reg  <= m_hit_reg;
            sv_reg   <= m_sv_reg;
            iv_reg   <= m_iv_reg;
            uses_reg <= m_uses_reg;
            s_reg    <= s_next;
            q_reg    <= q_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign hit                   = hit_reg;
    assign surface_valid         = sv_reg;
    assign surface_x             = s_reg[0];
    assign surface_y             = s_reg[1];
    assign surface_z             = s_reg[2];
    assign interior_valid        = iv_reg;
    assign interior_x            = q_reg[0];
    assign interior_y            = q_reg[1];
    assign interior_z            = q_reg[2];
    assign uses_effective_normal = uses_reg;

endmodule
